@@ rtl/arp_rr_pkg.sv @@
// Shared constants for the ARP request responder.
// No dependencies; imported by the top level and the testbench.
package arp_rr_pkg;

   localparam int unsigned ARP_LEN    = 42;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned REPLY_BITS = ARP_LEN * 8;

   localparam logic [CNT_W-1:0] POS_SRC_MAC   = CNT_W'(6);
   localparam logic [CNT_W-1:0] POS_TYPE      = CNT_W'(12);
   localparam logic [CNT_W-1:0] POS_HDR       = CNT_W'(14);
   localparam logic [CNT_W-1:0] POS_SNDR_HW   = CNT_W'(22);
   localparam logic [CNT_W-1:0] POS_SNDR_IP   = CNT_W'(28);
   localparam logic [CNT_W-1:0] POS_TGT_HW    = CNT_W'(32);
   localparam logic [CNT_W-1:0] POS_TGT_IP    = CNT_W'(38);
   localparam logic [CNT_W-1:0] POS_END       = CNT_W'(ARP_LEN);
   localparam logic [CNT_W-1:0] POS_LAST_BYTE = CNT_W'(ARP_LEN - 1);

   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [15:0] HTYPE_ETH  = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  HLEN_ETH   = 8'h06;
   localparam logic [7:0]  PLEN_IPV4  = 8'h04;
   localparam logic [15:0] OP_REPLY   = 16'h0002;

   localparam logic [7:0] ARP_FIXED_HDR [0:7] = '{
      8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
   };

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_MAC = 2'd0,
      CSR_HOST_IP = 2'd1,
      CSR_DNS_IP  = 2'd2
   } csr_index_type;

endpackage

@@ rtl/arp_rr_if.sv @@
// Valid/ready channels for frame requests and reply bytes.
// Depends on nothing beyond plain logic types.
interface arp_rr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface arp_rr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;

   modport source (output valid, output reply_byte, output reply_last, input ready);
   modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

@@ rtl/arp_request_responder_top.sv @@
// ARP request responder: frame parser, reply snapshot and reply serializer.
// Depends on arp_rr_pkg and the channel interfaces in arp_rr_if.sv.
//
// Usage:
//   req carries one Ethernet frame byte per request, frame_last on the final
//   byte. A byte is taken every cycle; only a final byte is held back while
//   the previous reply is still being sent.
//   rsp carries the 42-byte ARP reply, reply_last on the final byte. It is
//   produced when the frame is an ARP request for host_ip or dns_ip.
//   csr_we/csr_index/csr_wdata write own_mac (0), host_ip (1), dns_ip (2);
//   write only while no reply is pending.
// Timing: the final frame byte sets busy_ff and the snapshot, then the output
//   register loads the first reply byte; bytes then run at one per cycle while
//   rsp.ready is high, paced by the single output register and the byte index counter.
// Throughput: one request per cycle; a final byte that arrives while a reply
//   is in flight waits until the serializer frees its snapshot.
// Reset clears the parser, the serializer and the configuration registers to zero, but sets header_ok_ff to one.
// A stalled receiver holds the output register; the serializer waits with it.
module arp_request_responder_top (
   input  logic                             clock,
   input  logic                             reset,
   arp_rr_req_if.sink                       req,
   arp_rr_rsp_if.source                     rsp,
   input  logic                             csr_we,
   input  logic [arp_rr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arp_rr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import arp_rr_pkg::*;

   logic [47:0] own_mac_ff;
   logic [31:0] host_ip_ff;
   logic [31:0] dns_ip_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [47:0]      peer_mac_ff, peer_mac_in;
   logic [15:0]      frame_type_ff, frame_type_in;
   logic             header_ok_ff, header_ok_in;
   logic [47:0]      sender_hw_ff, sender_hw_in;
   logic [31:0]      sender_ip_ff, sender_ip_in;
   logic [31:0]      target_ip_ff, target_ip_in;

   logic [47:0] snap_peer_ff;
   logic [47:0] snap_sender_hw_ff;
   logic [31:0] snap_sender_ip_ff;
   logic [31:0] snap_target_ip_ff;
   logic        busy_ff;
   logic [CNT_W-1:0] idx_ff;

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic                  req_fire;
   logic                  answer;
   logic                  out_load;
   logic [CNT_W-1:0]      hdr_off;
   logic [REPLY_BITS-1:0] reply_vec;
   logic [8:0]            bit_off;
   logic [7:0]            reply_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         host_ip_ff <= '0;
         dns_ip_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_MAC: own_mac_ff <= csr_wdata[47:0];
            CSR_HOST_IP: host_ip_ff <= csr_wdata[31:0];
            CSR_DNS_IP:  dns_ip_ff  <= csr_wdata[31:0];
            default:     ;
         endcase
      end
   end

   assign req.ready = !(busy_ff && req.frame_last);
   assign req_fire  = req.valid && req.ready;
   assign hdr_off   = count_ff - POS_HDR;

   always_comb begin
      count_in      = count_ff;
      peer_mac_in   = peer_mac_ff;
      frame_type_in = frame_type_ff;
      header_ok_in  = header_ok_ff;
      sender_hw_in  = sender_hw_ff;
      sender_ip_in  = sender_ip_ff;
      target_ip_in  = target_ip_ff;
      if (count_ff < POS_END) begin
         if (count_ff >= POS_SRC_MAC && count_ff < POS_TYPE) begin
            peer_mac_in = {peer_mac_ff[39:0], req.frame_byte};
         end else if (count_ff >= POS_TYPE && count_ff < POS_HDR) begin
            frame_type_in = {frame_type_ff[7:0], req.frame_byte};
         end else if (count_ff >= POS_HDR && count_ff < POS_SNDR_HW) begin
            if (req.frame_byte != ARP_FIXED_HDR[hdr_off[2:0]]) begin
               header_ok_in = 1'b0;
            end
         end else if (count_ff >= POS_SNDR_HW && count_ff < POS_SNDR_IP) begin
            sender_hw_in = {sender_hw_ff[39:0], req.frame_byte};
         end else if (count_ff >= POS_SNDR_IP && count_ff < POS_TGT_HW) begin
            sender_ip_in = {sender_ip_ff[23:0], req.frame_byte};
         end else if (count_ff >= POS_TGT_IP) begin
            target_ip_in = {target_ip_ff[23:0], req.frame_byte};
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign answer = (count_in == POS_END) && (frame_type_in == ETYPE_ARP) && header_ok_in &&
                   ((target_ip_in == host_ip_ff) || (target_ip_in == dns_ip_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         peer_mac_ff   <= '0;
         frame_type_ff <= '0;
         header_ok_ff  <= 1'b1;
         sender_hw_ff  <= '0;
         sender_ip_ff  <= '0;
         target_ip_ff  <= '0;
      end else if (req_fire) begin
         if (req.frame_last) begin
            count_ff      <= '0;
            peer_mac_ff   <= '0;
            frame_type_ff <= '0;
            header_ok_ff  <= 1'b1;
            sender_hw_ff  <= '0;
            sender_ip_ff  <= '0;
            target_ip_ff  <= '0;
         end else begin
            count_ff      <= count_in;
            peer_mac_ff   <= peer_mac_in;
            frame_type_ff <= frame_type_in;
            header_ok_ff  <= header_ok_in;
            sender_hw_ff  <= sender_hw_in;
            sender_ip_ff  <= sender_ip_in;
            target_ip_ff  <= target_ip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req.frame_last && answer) begin
         snap_peer_ff      <= peer_mac_in;
         snap_sender_hw_ff <= sender_hw_in;
         snap_sender_ip_ff <= sender_ip_in;
         snap_target_ip_ff <= target_ip_in;
      end
   end

   assign reply_vec = {snap_peer_ff, own_mac_ff, ETYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
                       HLEN_ETH, PLEN_IPV4, OP_REPLY, own_mac_ff, snap_target_ip_ff,
                       snap_sender_hw_ff, snap_sender_ip_ff};
   assign bit_off   = 9'(REPLY_BITS - 8) - {idx_ff, 3'b000};
   assign reply_sel = reply_vec[bit_off +: 8];
   assign out_load  = busy_ff && (!out_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (req_fire && req.frame_last && answer) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (out_load) begin
         if (idx_ff == POS_LAST_BYTE) begin
            busy_ff <= 1'b0;
            idx_ff  <= '0;
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= reply_sel;
         out_last_ff <= (idx_ff == POS_LAST_BYTE);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.reply_byte = out_byte_ff;
   assign rsp.reply_last = out_last_ff;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for arp_request_responder_top: drives Ethernet frames byte by byte,
// predicts the 42-byte ARP replies and compares every reply byte.
// Depends on arp_rr_pkg, the channel interfaces in arp_rr_if.sv and the top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arp_rr_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int LIMIT_CYCLES  = 400_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 60;
   localparam int RANDOM_BYTES  = 220;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   arp_rr_req_if req_if ();
   arp_rr_rsp_if rsp_if ();

   arp_request_responder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // register copies and frame parser state
   logic [47:0]      cfg_own_mac  = '0;
   logic [31:0]      cfg_host_ip  = '0;
   logic [31:0]      cfg_dns_ip   = '0;
   logic [CNT_W-1:0] rx_count     = '0;
   logic [47:0]      rx_peer_mac  = '0;
   logic [15:0]      rx_ethertype = '0;
   logic             rx_hdr_ok    = 1'b1;
   logic [47:0]      rx_sha       = '0;
   logic [31:0]      rx_spa       = '0;
   logic [31:0]      rx_tpa       = '0;

   reply_byte_type expected_reply [$];
   logic [7:0]     frame_buf [$];

   int mismatches      = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_off_cycles = 0;
   int random_bytes    = 0;

   function automatic void absorb_frame_byte(input logic [7:0] b, input logic last);
      logic [REPLY_BITS-1:0] img;
      reply_byte_type        beat;
      if (rx_count < POS_END) begin
         if (rx_count >= POS_SRC_MAC && rx_count < POS_TYPE) begin
            rx_peer_mac = {rx_peer_mac[39:0], b};
         end else if (rx_count >= POS_TYPE && rx_count < POS_HDR) begin
            rx_ethertype = {rx_ethertype[7:0], b};
         end else if (rx_count >= POS_HDR && rx_count < POS_SNDR_HW) begin
            if (b != ARP_FIXED_HDR[rx_count - POS_HDR]) rx_hdr_ok = 1'b0;
         end else if (rx_count >= POS_SNDR_HW && rx_count < POS_SNDR_IP) begin
            rx_sha = {rx_sha[39:0], b};
         end else if (rx_count >= POS_SNDR_IP && rx_count < POS_TGT_HW) begin
            rx_spa = {rx_spa[23:0], b};
         end else if (rx_count >= POS_TGT_IP) begin
            rx_tpa = {rx_tpa[23:0], b};
         end
         rx_count = rx_count + 1'b1;
      end
      if (!last) return;
      if (rx_count == POS_END && rx_ethertype == ETYPE_ARP && rx_hdr_ok &&
          (rx_tpa == cfg_host_ip || rx_tpa == cfg_dns_ip)) begin
         img = {rx_peer_mac, cfg_own_mac, ETYPE_ARP, HTYPE_ETH, PTYPE_IPV4, HLEN_ETH,
                PLEN_IPV4, OP_REPLY, cfg_own_mac, rx_tpa, rx_sha, rx_spa};
         for (int k = 0; k < ARP_LEN; k++) begin
            beat.data = img[REPLY_BITS - 1 - 8 * k -: 8];
            beat.last = (k == ARP_LEN - 1);
            expected_reply.push_back(beat);
         end
      end
      rx_count     = '0;
      rx_peer_mac  = '0;
      rx_ethertype = '0;
      rx_hdr_ok    = 1'b1;
      rx_sha       = '0;
      rx_spa       = '0;
      rx_tpa       = '0;
   endfunction

   always @(posedge clock) begin : reply_check
      reply_byte_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_reply.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected reply byte: expected none, got %02h last %0b",
                     $time, rsp_if.reply_byte, rsp_if.reply_last);
         end else begin
            want = expected_reply.pop_front();
            if (rsp_if.reply_byte !== want.data) begin
               mismatches++;
               $display("%0t: reply_byte mismatch: expected %02h, got %02h",
                        $time, want.data, rsp_if.reply_byte);
            end
            if (rsp_if.reply_last !== want.last) begin
               mismatches++;
               $display("%0t: reply_last mismatch: expected %0b, got %0b",
                        $time, want.last, rsp_if.reply_last);
            end
         end
      end
   end

   initial begin : rsp_drive
      int n;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_if.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.frame_byte <= b;
      req_if.frame_last <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      absorb_frame_byte(b, last);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic drain_replies(input int settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_reply.size() != 0) @(posedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_if.valid <= 1'b0;
      csr_we       <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OWN_MAC: cfg_own_mac = data[47:0];
         CSR_HOST_IP: cfg_host_ip = data[31:0];
         CSR_DNS_IP:  cfg_dns_ip  = data[31:0];
         default: ;
      endcase
   endtask

   task automatic set_idling(input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
   endtask

   function automatic void push_be(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) frame_buf.push_back(v[8 * i +: 8]);
   endfunction

   function automatic void build_request(input logic [47:0] dst, input logic [47:0] src,
                                         input logic [31:0] spa, input logic [31:0] tpa);
      frame_buf.delete();
      push_be(dst, 6);
      push_be(src, 6);
      push_be(ETYPE_ARP, 2);
      for (int i = 0; i < 8; i++) frame_buf.push_back(ARP_FIXED_HDR[i]);
      push_be(src, 6);
      push_be(spa, 4);
      push_be(64'($urandom), 6);
      push_be(tpa, 4);
   endfunction

   function automatic logic [47:0] rand_mac();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_reset_defaults();
      set_idling(0, 0);
      build_request('1, 48'h0, 32'h0, 32'h0);
      send_frame();
      build_request('1, 48'h0200_0000_0001, 32'h0A00_020F, 32'hC0A8_0001);
      send_frame();
      drain_replies(SETTLE_CYCLES);
   endtask

   task automatic test_config_writes();
      csr_write(CSR_OWN_MAC, 48'h5254_0012_3502);
      csr_write(CSR_HOST_IP, 48'hFFFF_0A00_0202);
      csr_write(CSR_DNS_IP, 48'hABCD_0A00_0203);
      csr_write(CSR_IDX_SPARE, '1);
      build_request('1, 48'h5255_0A00_0215, 32'h0A00_020F, 32'h0A00_0202);
      send_frame();
      build_request(48'h5254_0012_3502, 48'h5255_0A00_0215, 32'h0A00_020F, 32'h0A00_0203);
      send_frame();
      build_request('1, 48'h5255_0A00_0215, 32'h0A00_020F, 32'h0);
      send_frame();
      build_request('1, 48'h5255_0A00_0215, 32'h0A00_020F, 32'h0A00_0204);
      send_frame();
      drain_replies(SETTLE_CYCLES);
   endtask

   task automatic test_header_checks();
      set_idling(36, 36);
      for (int pos = POS_TYPE; pos < POS_SNDR_HW; pos++) begin
         build_request('1, rand_mac(), $urandom, cfg_host_ip);
         // turn the opcode byte into a reply opcode, flip one bit elsewhere
         frame_buf[pos] = frame_buf[pos] ^ ((pos == POS_SNDR_HW - 1) ? 8'h03 : 8'h01);
         send_frame();
      end
      drain_replies(SETTLE_CYCLES);
      set_idling(0, 0);
   endtask

   task automatic test_frame_lengths();
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      send_frame();
      build_request('1, rand_mac(), $urandom, cfg_dns_ip);
      void'(frame_buf.pop_back());
      send_frame();
      build_request('1, rand_mac(), $urandom, cfg_dns_ip);
      send_frame();
      build_request('1, rand_mac(), $urandom, cfg_host_ip);
      frame_buf.push_back(8'h00);
      send_frame();
      build_request('1, rand_mac(), $urandom, cfg_host_ip);
      while (frame_buf.size() < 100) frame_buf.push_back(8'($urandom));
      send_frame();
      drain_replies(SETTLE_CYCLES);
   endtask

   task automatic test_field_extremes();
      csr_write(CSR_OWN_MAC, '1);
      csr_write(CSR_HOST_IP, '1);
      csr_write(CSR_DNS_IP, '0);
      build_request('1, '1, '1, '1);
      send_frame();
      build_request('0, '0, '0, '0);
      send_frame();
      drain_replies(SETTLE_CYCLES);
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      hold_off_cycles = 300;
      for (int i = 0; i < 3; i++) begin
         build_request(rand_mac(), rand_mac(), $urandom, i[0] ? cfg_dns_ip : cfg_host_ip);
         send_frame();
      end
      drain_replies(SETTLE_CYCLES);
      set_idling(36, 36);
      hold_off_cycles = 150;
      for (int i = 0; i < 2; i++) begin
         build_request(rand_mac(), rand_mac(), $urandom, cfg_host_ip);
         send_frame();
      end
      drain_replies(SETTLE_CYCLES);
   endtask

   task automatic rand_config();
      case ($urandom_range(3))
         0: csr_write(CSR_OWN_MAC, '0);
         1: csr_write(CSR_OWN_MAC, '1);
         default: csr_write(CSR_OWN_MAC, rand_mac());
      endcase
      case ($urandom_range(3))
         0: csr_write(CSR_HOST_IP, '1);
         default: csr_write(CSR_HOST_IP, {16'($urandom), 32'($urandom)});
      endcase
      case ($urandom_range(3))
         0: csr_write(CSR_DNS_IP, {16'($urandom), cfg_host_ip});
         1: csr_write(CSR_DNS_IP, '0);
         default: csr_write(CSR_DNS_IP, {16'($urandom), 32'($urandom)});
      endcase
      if ($urandom_range(3) == 0) csr_write(CSR_IDX_SPARE, rand_mac());
   endtask

   task automatic random_frame();
      int          kind;
      int          n;
      logic [31:0] tpa;
      kind = $urandom_range(99);
      if (kind >= 72 && kind < 80) tpa = $urandom;
      else tpa = $urandom_range(1) ? cfg_host_ip : cfg_dns_ip;
      build_request($urandom_range(1) ? '1 : rand_mac(), rand_mac(), $urandom, tpa);
      if (kind < 60) begin
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 30);
            repeat (n) frame_buf.push_back(8'($urandom));
         end
      end else if (kind < 72) begin
         n = $urandom_range(POS_TYPE, POS_SNDR_HW - 1);
         frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      end else if (kind >= 80 && kind < 92) begin
         n = $urandom_range(1, ARP_LEN - 1);
         while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end else if (kind >= 92) begin
         frame_buf.delete();
         n = $urandom_range(1, 60);
         repeat (n) frame_buf.push_back(8'($urandom));
      end
      random_bytes += (frame_buf.size() < ARP_LEN) ? frame_buf.size() : ARP_LEN;
      send_frame();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(68, 0);
            2: set_idling(0, 68);
            default: set_idling(36, 36);
         endcase
         rand_config();
         while (random_bytes < (phase + 1) * RANDOM_BYTES / 4) random_frame();
         drain_replies(SETTLE_CYCLES);
      end
   endtask

   initial begin : stimulus
      req_if.valid      = 1'b0;
      req_if.frame_byte = '0;
      req_if.frame_last = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_config_writes();
      test_header_checks();
      test_frame_lengths();
      test_field_extremes();
      test_backpressure();
      test_random_traffic();
      drain_replies(TAIL_CYCLES);
      mismatches += expected_reply.size();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ arp_request_responder_top.f @@
rtl/arp_rr_pkg.sv
rtl/arp_rr_if.sv
rtl/arp_request_responder_top.sv
test/tb_top.sv
